// File: rtl/core/jpeg_frame_size_parser_assert.svh
// ----------------------------------------------------------------------------
// JPEG frame size parser assertion macros
// Small wrappers for the concurrent checks used in the parser RTL.
// ----------------------------------------------------------------------------
`ifndef JPEG_FRAME_SIZE_PARSER_ASSERT_SVH
`define JPEG_FRAME_SIZE_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JFSP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JFSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/jfsp_pkg.sv
// ----------------------------------------------------------------------------
// JPEG frame size parser package
// Status codes, marker codes and the frame marker test.
// ----------------------------------------------------------------------------
package jfsp_pkg;

  // Result status codes.
  localparam logic [2:0] StatusFound     = 3'd0;
  localparam logic [2:0] StatusNoStart   = 3'd1;
  localparam logic [2:0] StatusEndOrScan = 3'd2;
  localparam logic [2:0] StatusTruncated = 3'd3;
  localparam logic [2:0] StatusBadLength = 3'd4;
  localparam logic [2:0] StatusZeroSize  = 3'd5;

  // Marker codes.
  localparam logic [7:0] MarkerPrefix = 8'hFF;
  localparam logic [7:0] MarkerSoi    = 8'hD8;
  localparam logic [7:0] MarkerEoi    = 8'hD9;
  localparam logic [7:0] MarkerSos    = 8'hDA;
  localparam logic [7:0] MarkerSofLo  = 8'hC0;
  localparam logic [7:0] MarkerSofHi  = 8'hCF;
  localparam logic [7:0] MarkerDht    = 8'hC4;
  localparam logic [7:0] MarkerJpg    = 8'hC8;
  localparam logic [7:0] MarkerDac    = 8'hCC;

  // True for the start-of-frame family, which excludes the table and
  // extension codes that share the same range.
  function automatic logic is_frame_marker(logic [7:0] code);
    logic in_range;
    in_range = code inside {[MarkerSofLo:MarkerSofHi]};
    return in_range && (code != MarkerDht) && (code != MarkerJpg) && (code != MarkerDac);
  endfunction

endpackage

// File: rtl/core/jfsp_in_if.sv
// ----------------------------------------------------------------------------
// JPEG frame size parser byte channel
// Valid/ready channel carrying one file byte and its end-of-file flag.
// ----------------------------------------------------------------------------
interface jfsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_end;

  modport source (output valid, output data_byte, output file_end, input ready);
  modport sink (input valid, input data_byte, input file_end, output ready);
endinterface

// File: rtl/core/jfsp_out_if.sv
// ----------------------------------------------------------------------------
// JPEG frame size parser result channel
// Valid/ready channel carrying the parse status and the image dimensions.
// ----------------------------------------------------------------------------
interface jfsp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] image_width;
  logic [15:0] image_height;

  modport source (output valid, output status, output image_width, output image_height,
                  input ready);
  modport sink (input valid, input status, input image_width, input image_height,
                output ready);
endinterface

// File: rtl/core/jpeg_frame_size_parser.sv
// ----------------------------------------------------------------------------
// JPEG frame size parser
// Walks the marker segments of a JPEG byte stream and reports the frame
// height and width, or the reason the parse failed, once per file.
//
//   Channel  Dir  Payload                              Transfer when
//   in_i     in   data_byte[7:0], file_end             valid && ready
//   out_o    out  status[2:0], image_width[15:0],      valid && ready
//                 image_height[15:0]
//
// One byte is accepted per cycle. A byte is held in the input register,
// where the parse state is updated, and any result it produces is loaded
// into the result register as the byte moves on, and is sent from there.
// The input side stalls only while a result waits in the result register
// and the output side is not ready. Reset clears the parse state to
// "expect start of image"; file_end on a byte also returns it there.
// ----------------------------------------------------------------------------
module jpeg_frame_size_parser (
  input  logic  clk_i,
  input  logic  rst_ni,
  jfsp_in_if.sink    in_i,
  jfsp_out_if.source out_o
);
  import jfsp_pkg::*;

  typedef enum logic [3:0] {
    PhStart0,
    PhStart1,
    PhMark,
    PhLenHi,
    PhLenLo,
    PhSkip,
    PhPrec,
    PhHHi,
    PhHLo,
    PhWHi,
    PhWLo,
    PhDone
  } phase_e;

  // Input register.
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       s1_fire;

  // Parse state.
  phase_e      phase_q, phase_d;
  logic [7:0]  marker_q, marker_d;
  logic [15:0] count_q, count_d;
  logic [15:0] height_q, height_d;
  logic [7:0]  width_hi_q, width_hi_d;
  logic        given_q, given_d;

  // Step outputs.
  logic        emit;
  logic [2:0]  emit_status;
  logic [15:0] emit_width;
  logic [15:0] emit_height;
  logic [15:0] seg_len;
  logic [15:0] width_full;

  // Result register.
  logic        res_valid_q;
  logic [2:0]  res_status_q;
  logic [15:0] res_width_q;
  logic [15:0] res_height_q;

  // The input register moves on whenever the result register has room.
  assign s1_fire    = s1_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.data_byte;
      s1_last_q <= in_i.file_end;
    end
  end

  assign seg_len    = {count_q[7:0], s1_byte_q};
  assign width_full = {width_hi_q, s1_byte_q};

  // One parse step for the byte in the input register.
  always_comb begin
    phase_d     = phase_q;
    marker_d    = marker_q;
    count_d     = count_q;
    height_d    = height_q;
    width_hi_d  = width_hi_q;
    given_d     = given_q;
    emit        = 1'b0;
    emit_status = StatusFound;
    emit_width  = '0;
    emit_height = '0;

    case (phase_q)
      PhStart0: begin
        if (s1_byte_q == MarkerPrefix) begin
          phase_d = PhStart1;
        end else begin
          emit        = 1'b1;
          emit_status = StatusNoStart;
        end
      end
      PhStart1: begin
        if (s1_byte_q == MarkerSoi) begin
          phase_d = PhMark;
        end else begin
          emit        = 1'b1;
          emit_status = StatusNoStart;
        end
      end
      PhMark: begin
        // Fill bytes are skipped; anything else is the marker code.
        if (s1_byte_q != MarkerPrefix) begin
          marker_d = s1_byte_q;
          if (s1_byte_q == MarkerEoi || s1_byte_q == MarkerSos) begin
            emit        = 1'b1;
            emit_status = StatusEndOrScan;
          end else begin
            phase_d = PhLenHi;
          end
        end
      end
      PhLenHi: begin
        count_d = {8'h00, s1_byte_q};
        phase_d = PhLenLo;
      end
      PhLenLo: begin
        if (seg_len < 16'd2) begin
          emit        = 1'b1;
          emit_status = StatusBadLength;
        end else if (is_frame_marker(marker_q)) begin
          phase_d = PhPrec;
        end else begin
          count_d = seg_len - 16'd2;
          phase_d = (seg_len == 16'd2) ? PhMark : PhSkip;
        end
      end
      PhSkip: begin
        count_d = count_q - 16'd1;
        if (count_q == 16'd1) begin
          phase_d = PhMark;
        end
      end
      PhPrec: begin
        phase_d = PhHHi;
      end
      PhHHi: begin
        height_d = {s1_byte_q, 8'h00};
        phase_d  = PhHLo;
      end
      PhHLo: begin
        height_d = {height_q[15:8], s1_byte_q};
        phase_d  = PhWHi;
      end
      PhWHi: begin
        width_hi_d = s1_byte_q;
        phase_d    = PhWLo;
      end
      PhWLo: begin
        emit = 1'b1;
        if (width_full == 16'd0 || height_q == 16'd0) begin
          emit_status = StatusZeroSize;
        end else begin
          emit_status = StatusFound;
          emit_width  = width_full;
          emit_height = height_q;
        end
      end
      default: begin
      end
    endcase

    if (emit) begin
      given_d = 1'b1;
      phase_d = PhDone;
    end

    // The final byte closes the file: report a short file if nothing was
    // reported yet, then return to the initial state.
    if (s1_last_q) begin
      if (!emit && !given_q) begin
        emit = 1'b1;
        if (phase_d == PhStart0 || phase_d == PhStart1) begin
          emit_status = StatusNoStart;
        end else begin
          emit_status = StatusTruncated;
        end
      end
      phase_d    = PhStart0;
      marker_d   = '0;
      count_d    = '0;
      height_d   = '0;
      width_hi_d = '0;
      given_d    = 1'b0;
    end
  end

  // Parse state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhStart0;
      marker_q     <= '0;
      count_q      <= '0;
      height_q     <= '0;
      width_hi_q   <= '0;
      given_q      <= 1'b0;
      res_valid_q  <= 1'b0;
      res_status_q <= StatusFound;
      res_width_q  <= '0;
      res_height_q <= '0;
    end else begin
      if (s1_fire) begin
        phase_q    <= phase_d;
        marker_q   <= marker_d;
        count_q    <= count_d;
        height_q   <= height_d;
        width_hi_q <= width_hi_d;
        given_q    <= given_d;
      end
      // The result register is loaded by a step that reports and cleared by a
      // transfer.
      if (s1_fire && emit) begin
        res_valid_q  <= 1'b1;
        res_status_q <= emit_status;
        res_width_q  <= emit_width;
        res_height_q <= emit_height;
      end else if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid        = res_valid_q;
  assign out_o.status       = res_status_q;
  assign out_o.image_width  = res_width_q;
  assign out_o.image_height = res_height_q;

  `include "jpeg_frame_size_parser_assert.svh"

  `JFSP_ASSERT_IMPL(a_fail_zero_size, clk_i, rst_ni,
    res_valid_q && res_status_q != StatusFound,
    res_width_q == 16'd0 && res_height_q == 16'd0, "failed result carries nonzero size")
  `JFSP_ASSERT_IMPL(a_found_nonzero, clk_i, rst_ni,
    res_valid_q && res_status_q == StatusFound,
    res_width_q != 16'd0 && res_height_q != 16'd0, "found result has a zero dimension")
  `JFSP_ASSERT_IMPL(a_given_done, clk_i, rst_ni, given_q, phase_q == PhDone,
    "result flag set outside the done phase")
  `JFSP_ASSERT_IMPL(a_done_given, clk_i, rst_ni, phase_q == PhDone, given_q,
    "done phase without a result")
  `JFSP_ASSERT_NEXT(a_last_resets, clk_i, rst_ni, s1_fire && s1_last_q,
    phase_q == PhStart0 && !given_q, "parse state not cleared after the final byte")
  `JFSP_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni,
    s1_valid_q && res_valid_q && !out_o.ready,
    s1_valid_q && $stable(phase_q) && $stable(count_q),
    "parse state moved while the result was stalled")

endmodule

// File: test/jfsp_size_checker.sv
// ----------------------------------------------------------------------------
// JPEG frame size parser scoreboard
// Watches the byte and result channels of the parser, walks every accepted
// byte through its own copy of the segment parser, and compares each result
// transfer field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module jfsp_size_checker (
  input  logic clk_i,
  input  logic rst_ni,
  jfsp_in_if   in_i,
  jfsp_out_if  out_i,
  output int   mismatches_o,
  output int   sizes_pending_o
);
  import jfsp_pkg::*;

  // Where the byte walk stands within the current file.
  typedef enum logic [3:0] {
    WaitPrefix,
    WaitSoi,
    SeekMarker,
    LenHigh,
    LenLow,
    SkipBody,
    Precision,
    HeightHigh,
    HeightLow,
    WidthHigh,
    WidthLow,
    Reported
  } walk_state_e;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] width;
    logic [15:0] height;
  } size_report_t;

  walk_state_e  walk_state;
  logic [7:0]   seg_code;
  logic [15:0]  seg_count;
  logic [15:0]  height_q;
  logic [7:0]   width_hi_q;
  logic         reported;
  size_report_t sizes_due[$];
  size_report_t oldest;

  // Back to the start of a file.
  task automatic clear_walk();
    walk_state = WaitPrefix;
    seg_code   = '0;
    seg_count  = '0;
    height_q   = '0;
    width_hi_q = '0;
    reported   = 1'b0;
  endtask

  // Advances the walk by one byte and queues the result it causes, if any.
  task automatic parse_byte(input logic [7:0] b, input logic last);
    logic         hit;
    size_report_t rep;
    logic [15:0]  seg_len;
    logic [15:0]  width;
    hit     = 1'b0;
    rep     = '0;
    seg_len = {seg_count[7:0], b};
    width   = {width_hi_q, b};
    case (walk_state)
      WaitPrefix: begin
        if (b == MarkerPrefix) begin
          walk_state = WaitSoi;
        end else begin
          hit        = 1'b1;
          rep.status = StatusNoStart;
        end
      end
      WaitSoi: begin
        if (b == MarkerSoi) begin
          walk_state = SeekMarker;
        end else begin
          hit        = 1'b1;
          rep.status = StatusNoStart;
        end
      end
      // Fill bytes are dropped; any other byte is taken as the marker code.
      SeekMarker: begin
        if (b != MarkerPrefix) begin
          seg_code = b;
          if (b == MarkerEoi || b == MarkerSos) begin
            hit        = 1'b1;
            rep.status = StatusEndOrScan;
          end else begin
            walk_state = LenHigh;
          end
        end
      end
      LenHigh: begin
        seg_count  = {8'h00, b};
        walk_state = LenLow;
      end
      LenLow: begin
        if (seg_len < 16'd2) begin
          hit        = 1'b1;
          rep.status = StatusBadLength;
        end else if (seg_code >= MarkerSofLo && seg_code <= MarkerSofHi &&
                     seg_code != MarkerDht && seg_code != MarkerJpg &&
                     seg_code != MarkerDac) begin
          walk_state = Precision;
        end else begin
          seg_count  = seg_len - 16'd2;
          walk_state = (seg_count == 16'd0) ? SeekMarker : SkipBody;
        end
      end
      SkipBody: begin
        seg_count = seg_count - 16'd1;
        if (seg_count == 16'd0) walk_state = SeekMarker;
      end
      Precision: walk_state = HeightHigh;
      HeightHigh: begin
        height_q   = {b, 8'h00};
        walk_state = HeightLow;
      end
      HeightLow: begin
        height_q[7:0] = b;
        walk_state    = WidthHigh;
      end
      WidthHigh: begin
        width_hi_q = b;
        walk_state = WidthLow;
      end
      WidthLow: begin
        hit = 1'b1;
        if (width == 16'd0 || height_q == 16'd0) begin
          rep.status = StatusZeroSize;
        end else begin
          rep.status = StatusFound;
          rep.width  = width;
          rep.height = height_q;
        end
      end
      default: ;
    endcase

    if (hit) begin
      walk_state = Reported;
      reported   = 1'b1;
      sizes_due.push_back(rep);
    end

    // The final byte closes the file: a file with no result yet reports why.
    if (last) begin
      if (!hit && !reported) begin
        rep        = '0;
        rep.status = (walk_state == WaitPrefix || walk_state == WaitSoi) ?
                     StatusNoStart : StatusTruncated;
        sizes_due.push_back(rep);
      end
      clear_walk();
    end
  endtask

  // Results are checked before the byte of the same edge is predicted, since a
  // byte can never produce its result in the cycle it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_walk();
      sizes_due.delete();
      mismatches_o = 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        if (sizes_due.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("%0t: result with none due: status %0d width %0d height %0d", $time,
                     out_i.status, out_i.image_width, out_i.image_height);
        end else begin
          oldest = sizes_due.pop_front();
          if (out_i.status != oldest.status || out_i.image_width != oldest.width ||
              out_i.image_height != oldest.height) begin
            mismatches_o++;
            if (mismatches_o <= 10)
              $display("%0t: result mismatch: expected status %0d width %0d height %0d, got %s",
                       $time, oldest.status, oldest.width, oldest.height,
                       $sformatf("status %0d width %0d height %0d", out_i.status,
                                 out_i.image_width, out_i.image_height));
          end
        end
      end
      if (in_i.valid && in_i.ready) parse_byte(in_i.data_byte, in_i.file_end);
    end
    sizes_pending_o = sizes_due.size();
  end

endmodule

// File: test/jpeg_frame_size_parser_tb.sv
// ----------------------------------------------------------------------------
// JPEG frame size parser testbench
// Feeds the parser a short set of hand-made files, then random files that are
// mostly well-formed segment chains with random content, plus broken and
// noise files. The sender works in bursts and the receiver stalls on its own
// pattern; a scoreboard beside the parser predicts and checks every result.
// ----------------------------------------------------------------------------
module jpeg_frame_size_parser_tb;
  import jfsp_pkg::*;

  // Marker codes used only to build stimulus.
  localparam logic [7:0] MarkerApp0 = 8'hE0;
  localparam logic [7:0] MarkerDqt  = 8'hDB;
  localparam logic [7:0] MarkerCom  = 8'hFE;

  localparam int unsigned RandomBytes = 1200;
  localparam int unsigned CycleLimit  = 500000;

  logic clk_i;
  logic rst_ni;

  jfsp_in_if  in_if ();
  jfsp_out_if out_if ();

  int          mismatches;
  int          sizes_pending;
  logic [7:0]  file_bytes[$];
  int unsigned bytes_sent  = 0;
  int unsigned burst_left  = 0;
  int unsigned stall_span  = 0;
  int unsigned stall_kind  = 0;
  logic        paused_once = 1'b0;

  jpeg_frame_size_parser u_top (
    .clk_i,
    .rst_ni,
    .in_i  (in_if),
    .out_o (out_if)
  );

  jfsp_size_checker u_checker (
    .clk_i,
    .rst_ni,
    .in_i            (in_if),
    .out_i           (out_if),
    .mismatches_o    (mismatches),
    .sizes_pending_o (sizes_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case the parser hangs.
  initial begin
    #(CycleLimit * 20);
    $display("Regression FAIL");
    $finish;
  end

  // Result side: each span picks how the receiver behaves.
  always @(posedge clk_i) begin
    if (stall_span == 0) begin
      stall_kind <= $urandom_range(0, 3);
      stall_span <= $urandom_range(8, 80);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_kind)
      0:       out_if.ready <= 1'b1;
      1:       out_if.ready <= 1'($urandom_range(0, 1));
      2:       out_if.ready <= ($urandom_range(0, 7) != 0);
      default: out_if.ready <= ((stall_span % 8) < 2);
    endcase
  end

  // One byte transfer, with a random gap before each new burst.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.file_end  <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    burst_left--;
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
    bytes_sent += file_bytes.size();
  endtask

  // Holds the sender off until every predicted result has been seen.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sizes_pending != 0) @(posedge clk_i);
  endtask

  task automatic put_random(input int unsigned count);
    repeat (count) file_bytes.push_back(8'($urandom));
  endtask

  // Marker with optional fill bytes; rarely the prefix is left out.
  task automatic put_marker(input logic [7:0] code);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) file_bytes.push_back(MarkerPrefix);
    if ($urandom_range(0, 19) != 0) file_bytes.push_back(MarkerPrefix);
    file_bytes.push_back(code);
  endtask

  task automatic put_length(input logic [15:0] len);
    file_bytes.push_back(len[15:8]);
    file_bytes.push_back(len[7:0]);
  endtask

  function automatic logic [7:0] pick_other_code();
    case ($urandom_range(0, 5))
      0:       return MarkerDht;
      1:       return MarkerJpg;
      2:       return MarkerDac;
      3:       return MarkerApp0 + 8'($urandom_range(0, 15));
      4:       return MarkerDqt;
      default: return MarkerCom;
    endcase
  endfunction

  function automatic logic [7:0] pick_frame_code();
    logic [7:0] code;
    code = MarkerSofLo + 8'($urandom_range(0, 15));
    while (code == MarkerDht || code == MarkerJpg || code == MarkerDac)
      code = MarkerSofLo + 8'($urandom_range(0, 15));
    return code;
  endfunction

  function automatic logic [15:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'd1;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  // Segments that the parser only skips over.
  task automatic put_skip_segments(input int unsigned count);
    int unsigned body;
    repeat (count) begin
      body = $urandom_range(0, 6);
      put_marker(pick_other_code());
      put_length(16'(body + 2));
      put_random(body);
    end
  endtask

  initial begin
    int unsigned pick;
    int unsigned cut;
    logic [15:0] dim;

    in_if.valid     <= 1'b0;
    in_if.data_byte <= '0;
    in_if.file_end  <= 1'b0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Hand-made files: bad first byte, file too short for the start marker,
    // end-of-image, scan marker after fill bytes, a marker with no prefix and a
    // length of one, a file that stops after the start marker, and a frame of
    // maximum size behind a skipped table, ending on its last size byte.
    file_bytes = {8'h00};
    send_file();
    file_bytes = {MarkerPrefix};
    send_file();
    file_bytes = {MarkerPrefix, MarkerSoi, MarkerEoi};
    send_file();
    file_bytes = {MarkerPrefix, MarkerSoi, MarkerPrefix, MarkerPrefix, MarkerSos};
    send_file();
    file_bytes = {MarkerPrefix, MarkerSoi, MarkerSofLo, 8'h00, 8'h01};
    send_file();
    file_bytes = {MarkerPrefix, MarkerSoi};
    send_file();
    file_bytes = {MarkerPrefix, MarkerSoi, MarkerDht, 8'h00, 8'h02, MarkerSofHi, 8'h00, 8'h02,
                  8'h08, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_file();
    wait_drained();

    // Random files until enough bytes have gone in.
    while (bytes_sent < RandomBytes + 30) begin
      if (!paused_once && bytes_sent > RandomBytes / 2) begin
        wait_drained();
        paused_once = 1'b1;
      end
      pick = $urandom_range(0, 99);
      file_bytes.delete();
      if (pick < 70) begin
        // Well-formed chain ending in a frame header, sometimes cut short.
        file_bytes = {MarkerPrefix, MarkerSoi};
        put_skip_segments($urandom_range(0, 3));
        put_marker(pick_frame_code());
        put_length(($urandom_range(0, 3) == 0) ? 16'($urandom_range(2, 65535)) : 16'd17);
        put_random(1);
        dim = pick_dim();
        put_length(dim);
        dim = pick_dim();
        put_length(dim);
        put_random($urandom_range(0, 4));
        if ($urandom_range(0, 6) == 0) begin
          cut = $urandom_range(1, file_bytes.size());
          file_bytes = file_bytes[0:cut - 1];
        end
      end else if (pick < 85) begin
        // Broken chain: end or scan marker, bad length, or a skip past the end.
        file_bytes = {MarkerPrefix, MarkerSoi};
        put_skip_segments($urandom_range(0, 2));
        case ($urandom_range(0, 3))
          0: put_marker(MarkerEoi);
          1: put_marker(MarkerSos);
          2: begin
            put_marker(($urandom_range(0, 1) == 0) ? pick_frame_code() : pick_other_code());
            put_length(16'($urandom_range(0, 1)));
          end
          default: begin
            put_marker(pick_other_code());
            put_length(16'($urandom_range(256, 65535)));
            put_random($urandom_range(0, 10));
          end
        endcase
        put_random($urandom_range(0, 4));
      end else begin
        // Noise, half of it opening with a marker prefix.
        if ($urandom_range(0, 1) == 0) file_bytes.push_back(MarkerPrefix);
        put_random($urandom_range(1, 8));
      end
      send_file();
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && sizes_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/jfsp_pkg.sv
rtl/core/jfsp_in_if.sv
rtl/core/jfsp_out_if.sv
rtl/core/jpeg_frame_size_parser.sv
test/jfsp_size_checker.sv
test/jpeg_frame_size_parser_tb.sv
